// ----- hdl/rte_pkg.sv -----
package rte_pkg;

  localparam int NodeCountDef    = 256;
  localparam int ValueWidthDef   = 32;
  localparam int MaxLevelBitsDef = 10;
  localparam int MaxLevelsDef    = 8;

  localparam int KeyWidth   = 64;
  localparam int OpWidth    = 2;
  localparam int NarrowBits = 10;
  localparam int WideBits   = 8;
  localparam int NarrowLevels = 2;
  localparam int OutWidth   = 32;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

endpackage

// ----- hdl/rte_req_if.sv -----
interface rte_req_if;
  logic                            valid;
  logic                            ready;
  logic [rte_pkg::OpWidth-1:0]     op;
  logic [rte_pkg::KeyWidth-1:0]    key;
  logic [rte_pkg::OutWidth-1:0]    new_value;
  modport source (output valid, op, key, new_value, input ready);
  modport sink   (input valid, op, key, new_value, output ready);
endinterface

// ----- hdl/rte_rsp_if.sv -----
interface rte_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rte_pkg::OutWidth-1:0]  value;
  logic                          found;
  logic                          status;
  modport source (output valid, value, found, status, input ready);
  modport sink   (input valid, value, found, status, output ready);
endinterface

// ----- hdl/rte_slot_mem.sv -----
// Slot store: one read, one write per cycle, registered read data.
module rte_slot_mem #(
  parameter int AW = 18,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- hdl/radix_table_engine_top.sv -----
// Radix table engine: lookup, get-or-insert and remove over a node pool.
// Each tree level walked passes S_RD and S_WAIT; each level written passes S_ALLOC,
// S_ZERO (which clears every slot of the new node through the single slot write port)
// and, below the root, S_LINK; each level freed passes S_FREE. One transaction at a time.
// Reset (rst, synchronous) and any cfg_we (mode) write start a clearing pass over every
// slot address (slots, counts, free list); requests wait.
module radix_table_engine_top #(
  parameter int NODE_COUNT     = rte_pkg::NodeCountDef,
  parameter int VALUE_WIDTH    = rte_pkg::ValueWidthDef,
  parameter int MAX_LEVEL_BITS = rte_pkg::MaxLevelBitsDef,
  parameter int MAX_LEVELS     = rte_pkg::MaxLevelsDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  rte_req_if.sink    req,
  rte_rsp_if.source  rsp
);
  import rte_pkg::*;

  localparam int NW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW  = $clog2(NODE_COUNT + 1);
  localparam int SW  = MAX_LEVEL_BITS;
  localparam int AW  = NW + SW;
  localparam int OCW = SW + 1;
  localparam int LW  = $clog2(MAX_LEVELS + 1);
  localparam int PW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int SLOTW = (VALUE_WIDTH > NW + 1) ? VALUE_WIDTH : NW + 1;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_RD     = 11'b00000000100,
    S_WAIT   = 11'b00000001000,
    S_CHK    = 11'b00000010000,
    S_ALLOC  = 11'b00000100000,
    S_ZERO   = 11'b00001000000,
    S_LINK   = 11'b00010000000,
    S_LEAF   = 11'b00100000000,
    S_FREE   = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state;
  logic   mode;
  logic [OpWidth-1:0]     op;
  logic [KeyWidth-1:0]    key;
  logic [VALUE_WIDTH-1:0] nv;
  logic [NW-1:0]          path [MAX_LEVELS];
  logic [LW-1:0]          lvl;
  logic [LW-1:0]          depth;
  logic [AW-1:0]          clr_addr;
  logic [SW-1:0]          zero_cnt;
  logic [VALUE_WIDTH-1:0] val;
  logic [NW-1:0]          root_node;
  logic                   root_present;
  logic [CW-1:0]          free_cnt;
  logic [NW-1:0]          free_list [NODE_COUNT];
  logic [OCW-1:0]         occ [NODE_COUNT];
  logic [NW-1:0]          new_node;
  logic [OutWidth-1:0]    out_value;
  logic                   out_found, out_status;

  // occupancy memory ports; occ_cur tracks the count of the node being freed
  logic                   occ_we;
  logic [NW-1:0]          occ_wa, occ_ra;
  logic [OCW-1:0]         occ_wd, occ_rd, occ_dec, occ_cur;

  // free list memory ports
  logic                   fl_we;
  logic [NW-1:0]          fl_wa, fl_wd, fl_ra, fl_rd;

  // slot memory ports
  logic             m_we;
  logic [AW-1:0]    m_wa, m_ra;
  logic [SLOTW-1:0] m_wd, m_rd;

  rte_slot_mem #(.AW(AW), .DW(SLOTW)) u_mem (
    .clk(clk), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
    .rd_addr(m_ra), .rd_data(m_rd)
  );

  logic [LW-1:0] levels;
  assign levels = mode ? LW'(MAX_LEVELS) : LW'(NarrowLevels);

  function automatic logic [SW-1:0] sub_of(input logic [KeyWidth-1:0] k,
                                           input logic md,
                                           input logic [LW-1:0] lv,
                                           input logic [LW-1:0] nl);
    logic [KeyWidth-1:0] s;
    logic [6:0] sh;
    begin
      if (md) begin
        sh = 7'(WideBits) * 7'(nl - 1 - lv);
        s = (k >> sh) & KeyWidth'(8'hFF);
      end else begin
        sh = (lv == '0) ? 7'(NarrowBits) : 7'd0;
        s = (k >> sh) & KeyWidth'(10'h3FF);
      end
      sub_of = s[SW-1:0];
    end
  endfunction

  logic [SW-1:0] cur_sub;
  logic [SW-1:0] par_sub;
  assign cur_sub = sub_of(key, mode, lvl, levels);
  assign par_sub = sub_of(key, mode, lvl - 1'b1, levels);

  logic [NW-1:0] cur_node, par_node, gpar_node;
  assign cur_node  = path[lvl[PW-1:0]];
  assign par_node  = path[PW'(lvl - 1'b1)];
  assign gpar_node = path[PW'(lvl - 2'd2)];

  logic need_ok;
  assign need_ok = CW'(levels - depth) <= free_cnt;

  logic child_ok;
  assign child_ok = (m_rd != '0) && (m_rd <= SLOTW'(NODE_COUNT));

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.value = out_value;
  assign rsp.found = out_found;
  assign rsp.status = out_status;

  always_comb begin
    m_we = 1'b0;
    m_wa = {cur_node, cur_sub};
    m_wd = '0;
    m_ra = {cur_node, cur_sub};
    case (state)
      S_CLEAR: begin m_we = 1'b1; m_wa = clr_addr; end
      S_ZERO:  begin m_we = 1'b1; m_wa = {new_node, zero_cnt}; end
      S_LINK:  begin
        m_we = 1'b1; m_wa = {par_node, par_sub};
        m_wd = SLOTW'(new_node) + SLOTW'(1);
      end
      S_LEAF:  begin
        m_we = 1'b1;
        m_wa = {cur_node, cur_sub};
        m_wd = (op == OP_INSERT) ? SLOTW'(nv) : '0;
      end
      S_FREE:  begin
        m_we = (lvl != '0) && (occ_cur == '0);
        m_wa = {par_node, par_sub};
      end
      default: ;
    endcase
  end

  // occupancy and free list access; reads are issued one state ahead of use
  always_comb begin
    occ_dec = (occ_rd != '0) ? occ_rd - 1'b1 : '0;
    occ_we  = 1'b0;
    occ_wa  = cur_node;
    occ_wd  = '0;
    occ_ra  = cur_node;
    fl_we   = 1'b0;
    fl_wa   = free_cnt[NW-1:0];
    fl_wd   = cur_node;
    fl_ra   = free_cnt[NW-1:0] - 1'b1;
    case (state)
      S_CLEAR: begin
        occ_we = 1'b1; occ_wa = clr_addr[NW-1:0];
        fl_we  = 1'b1; fl_wa = clr_addr[NW-1:0]; fl_wd = clr_addr[NW-1:0];
      end
      S_ZERO: begin
        occ_we = (zero_cnt == '1); occ_wa = new_node;
        occ_ra = par_node;
      end
      S_LINK: begin
        occ_we = 1'b1; occ_wa = par_node; occ_wd = occ_rd + 1'b1;
      end
      S_LEAF: begin
        occ_we = 1'b1;
        occ_wd = (op == OP_INSERT) ? occ_rd + 1'b1 : occ_dec;
        occ_ra = par_node;
      end
      S_FREE: begin
        occ_we = (occ_cur == '0) && (lvl != '0);
        occ_wa = par_node; occ_wd = occ_dec;
        occ_ra = gpar_node;
        fl_we  = (occ_cur == '0) && (free_cnt < CW'(NODE_COUNT));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ[occ_wa] <= occ_wd;
    occ_rd <= occ[occ_ra];
    if (fl_we) free_list[fl_wa] <= fl_wd;
    fl_rd <= free_list[fl_ra];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      free_cnt <= CW'(NODE_COUNT);
      root_present <= 1'b0;
      root_node <= '0;
      if (rst) mode <= 1'b0;
      else     mode <= cfg_wdata;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          op <= req.op; key <= req.key; nv <= VALUE_WIDTH'(req.new_value);
          lvl <= '0; depth <= '0; val <= '0;
          out_value <= '0; out_found <= 1'b0; out_status <= 1'b0;
          path[0] <= root_node;
          if (req.op == OP_NONE) state <= S_OUT;
          else if (!root_present) state <= S_CHK;
          else begin depth <= LW'(1); state <= S_RD; end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: begin
          // m_rd holds slot at (cur_node, cur_sub)
          if (lvl + 1'b1 == levels) begin
            val <= VALUE_WIDTH'(m_rd);
            state <= S_CHK;
          end else if (child_ok) begin
            path[PW'(lvl + 1'b1)] <= NW'(m_rd - SLOTW'(1));
            lvl <= lvl + 1'b1;
            depth <= depth + 1'b1;
            state <= S_RD;
          end else state <= S_CHK;
        end
        S_CHK: begin
          lvl <= depth;
          if (op == OP_LOOKUP) begin
            out_value <= OutWidth'(val); out_found <= (val != '0);
            state <= S_OUT;
          end else if (op == OP_INSERT) begin
            if (val != '0) begin
              out_value <= OutWidth'(val); out_found <= 1'b1; state <= S_OUT;
            end else if (nv == '0) state <= S_OUT;
            else if (!need_ok) begin out_status <= 1'b1; state <= S_OUT; end
            else if (depth == levels) begin lvl <= levels - 1'b1; state <= S_LEAF; end
            else state <= S_ALLOC;
          end else begin
            if (val == '0) state <= S_OUT;
            else begin lvl <= levels - 1'b1; state <= S_LEAF; end
          end
        end
        S_ALLOC: begin
          new_node <= fl_rd;
          free_cnt <= free_cnt - 1'b1;
          zero_cnt <= '0;
          state <= S_ZERO;
        end
        S_ZERO: begin
          zero_cnt <= zero_cnt + 1'b1;
          if (zero_cnt == '1) begin
            path[lvl[PW-1:0]] <= new_node;
            if (lvl == '0) begin
              root_node <= new_node; root_present <= 1'b1;
              if (lvl + 1'b1 == levels) state <= S_LEAF;
              else begin lvl <= lvl + 1'b1; state <= S_ALLOC; end
            end else state <= S_LINK;
          end
        end
        S_LINK: begin
          if (lvl + 1'b1 == levels) state <= S_LEAF;
          else begin lvl <= lvl + 1'b1; state <= S_ALLOC; end
        end
        S_LEAF: begin
          if (op == OP_INSERT) begin
            out_value <= OutWidth'(nv);
            state <= S_OUT;
          end else begin
            occ_cur <= occ_dec;
            out_value <= OutWidth'(val); out_found <= 1'b1;
            state <= S_FREE;
          end
        end
        S_FREE: begin
          if (occ_cur != '0) state <= S_OUT;
          else begin
            if (free_cnt < CW'(NODE_COUNT)) free_cnt <= free_cnt + 1'b1;
            if (lvl == '0) begin
              root_present <= 1'b0; root_node <= '0; state <= S_OUT;
            end else begin
              occ_cur <= occ_dec;
              lvl <= lvl - 1'b1;
            end
          end
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
